@@ design/kdfq_pkg.sv @@
package kdfq_pkg;

    localparam int FRAME_BYTES_DEF = 256;
    localparam int QUEUE_SLOTS_DEF = 8;

    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    typedef enum logic [1:0] {
        MODE_RX      = 2'd0,
        MODE_READ    = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_NOP     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_QUEUED = 3'd1,
        EV_FULL   = 3'd2,
        EV_BADESC = 3'd3,
        EV_LONG   = 3'd4
    } t_event;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  read_data;
        logic [8:0]  oldest_length;
        logic [2:0]  frames_queued;
        logic        inside_frame;
        logic [15:0] dropped_frames;
    } t_out_word;

endpackage

@@ design/kiss_deframer_frame_queue.sv @@
// Channel | Direction | Handshake                  | Word
// in      | input     | i_in_valid / o_in_ready    | i_in_data  (kdfq_pkg::t_in_word)
// out     | output    | o_out_valid / i_out_ready  | o_out_data (kdfq_pkg::t_out_word)
//
// One word per cycle unless the output stalls; each word passes the input register,
// then decode and store access into the result register.
// Frame bytes and slot lengths sit in memories with registered reads, one port each way.
// Reset (synchronous, active low) clears framing state, ring pointers and the drop count;
// memory contents are left as they are.
// A stalled output holds one result while the input register takes one further word.
module kiss_deframer_frame_queue #(
    parameter int FRAME_BYTES = kdfq_pkg::FRAME_BYTES_DEF,
    parameter int QUEUE_SLOTS = kdfq_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  kdfq_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output kdfq_pkg::t_out_word  o_out_data
);

    localparam int CW   = $clog2(FRAME_BYTES + 1);
    localparam int SW   = $clog2(QUEUE_SLOTS);
    localparam int SW1  = SW + 1;
    localparam int DEPTH = FRAME_BYTES * QUEUE_SLOTS;
    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = (CW > 8) ? CW : 8;

    // input register
    logic               r_in_v;
    kdfq_pkg::t_in_word r_in;
    logic               fire;

    // framing and ring state
    logic          r_open, n_open;
    logic          r_esc, n_esc;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_wslot, n_wslot;
    logic [SW-1:0] r_rslot, n_rslot;
    logic [AW-1:0] r_wbase, n_wbase;
    logic [AW-1:0] r_rbase, n_rbase;
    logic [15:0]   r_drop, n_drop;

    // memories
    logic [7:0]    r_frame_store [DEPTH];
    logic [CW-1:0] r_slot_len [QUEUE_SLOTS];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_len_rd;
    logic          r_len_byp;
    logic [CW-1:0] r_len_byp_val;

    // result register
    logic            r_out_v;
    kdfq_pkg::t_event r_ev;
    logic            r_hit;
    logic            r_nonempty;
    logic [2:0]      r_queued;
    logic            r_inside;
    logic [15:0]     r_dropped;

    kdfq_pkg::t_event ev;
    logic          store_we;
    logic [7:0]    store_val;
    logic [AW-1:0] store_addr;
    logic          len_we;
    logic          rd_hit;
    logic [AW-1:0] rd_addr;
    logic [SW-1:0] q_cur, q_next;
    logic [CW-1:0] head_len;
    logic [SW-1:0] w_inc, r_inc;
    logic [AW-1:0] wbase_inc, rbase_inc;

    function automatic logic [SW-1:0] qcount(input logic [SW-1:0] w, input logic [SW-1:0] r);
        logic [SW1-1:0] sum;
        begin
            if (w >= r) begin
                sum = SW1'(w) - SW1'(r);
            end else begin
                sum = SW1'(w) + SW1'(QUEUE_SLOTS) - SW1'(r);
            end
            return sum[SW-1:0];
        end
    endfunction

    assign fire       = r_in_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_in_v || fire;

    // length of the oldest frame as left by the previous word
    assign head_len = r_len_byp ? r_len_byp_val : r_len_rd;

    assign w_inc     = (r_wslot == SW'(QUEUE_SLOTS - 1)) ? '0 : r_wslot + 1'b1;
    assign r_inc     = (r_rslot == SW'(QUEUE_SLOTS - 1)) ? '0 : r_rslot + 1'b1;
    assign wbase_inc = (r_wslot == SW'(QUEUE_SLOTS - 1)) ? '0 : r_wbase + AW'(FRAME_BYTES);
    assign rbase_inc = (r_rslot == SW'(QUEUE_SLOTS - 1)) ? '0 : r_rbase + AW'(FRAME_BYTES);
    assign q_cur     = qcount(r_wslot, r_rslot);
    assign store_addr = r_wbase + AW'(r_cnt);
    assign rd_addr    = r_rbase + AW'(r_in.read_index);

    always_comb begin
        n_open    = r_open;
        n_esc     = r_esc;
        n_cnt     = r_cnt;
        n_wslot   = r_wslot;
        n_rslot   = r_rslot;
        n_wbase   = r_wbase;
        n_rbase   = r_rbase;
        n_drop    = r_drop;
        ev        = kdfq_pkg::EV_NONE;
        store_we  = 1'b0;
        store_val = r_in.rx_byte;
        len_we    = 1'b0;
        rd_hit    = 1'b0;
        case (kdfq_pkg::t_mode'(r_in.mode))
            kdfq_pkg::MODE_RX: begin
                if (r_in.rx_byte == kdfq_pkg::FEND) begin
                    if (r_open && r_cnt != '0) begin
                        if (w_inc == r_rslot) begin
                            ev = kdfq_pkg::EV_FULL;
                            if (r_drop != 16'hFFFF) begin
                                n_drop = r_drop + 16'd1;
                            end
                        end else begin
                            ev      = kdfq_pkg::EV_QUEUED;
                            len_we  = 1'b1;
                            n_wslot = w_inc;
                            n_wbase = wbase_inc;
                        end
                    end
                    n_open = 1'b1;
                    n_esc  = 1'b0;
                    n_cnt  = '0;
                end else if (r_open) begin
                    if (r_esc && r_in.rx_byte != kdfq_pkg::TFEND
                        && r_in.rx_byte != kdfq_pkg::TFESC) begin
                        ev     = kdfq_pkg::EV_BADESC;
                        n_open = 1'b0;
                        n_esc  = 1'b0;
                        n_cnt  = '0;
                    end else if (!r_esc && r_in.rx_byte == kdfq_pkg::FESC) begin
                        n_esc = 1'b1;
                    end else begin
                        // plain data or a resolved escape
                        n_esc = 1'b0;
                        if (r_esc) begin
                            store_val = (r_in.rx_byte == kdfq_pkg::TFEND) ?
                                        kdfq_pkg::FEND : kdfq_pkg::FESC;
                        end
                        if (r_cnt >= CW'(FRAME_BYTES)) begin
                            ev     = kdfq_pkg::EV_LONG;
                            n_open = 1'b0;
                            n_cnt  = '0;
                        end else begin
                            store_we = 1'b1;
                            n_cnt    = r_cnt + 1'b1;
                        end
                    end
                end
            end
            kdfq_pkg::MODE_READ: begin
                rd_hit = (q_cur != '0) && (CMPW'(r_in.read_index) < CMPW'(head_len));
            end
            kdfq_pkg::MODE_RELEASE: begin
                if (q_cur != '0) begin
                    n_rslot = r_inc;
                    n_rbase = rbase_inc;
                end
            end
            default: begin
            end
        endcase
        q_next = qcount(n_wslot, n_rslot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_esc     <= 1'b0;
            r_cnt     <= '0;
            r_wslot   <= '0;
            r_rslot   <= '0;
            r_wbase   <= '0;
            r_rbase   <= '0;
            r_drop    <= '0;
            r_out_v   <= 1'b0;
            r_len_byp <= 1'b0;
        end else begin
            if (fire) begin
                r_open    <= n_open;
                r_esc     <= n_esc;
                r_cnt     <= n_cnt;
                r_wslot   <= n_wslot;
                r_rslot   <= n_rslot;
                r_wbase   <= n_wbase;
                r_rbase   <= n_rbase;
                r_drop    <= n_drop;
                r_len_byp <= len_we && (r_wslot == n_rslot);
                r_out_v   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ev          <= ev;
            r_hit         <= rd_hit;
            r_nonempty    <= q_next != '0;
            r_queued      <= 3'(q_next);
            r_inside      <= n_open;
            r_dropped     <= n_drop;
            r_len_byp_val <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && store_we) begin
            r_frame_store[store_addr] <= store_val;
        end
        if (fire && rd_hit) begin
            r_rd_data <= r_frame_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && len_we) begin
            r_slot_len[r_wslot] <= r_cnt;
        end
        if (fire) begin
            r_len_rd <= r_slot_len[n_rslot];
        end
    end

    assign o_out_valid                  = r_out_v;
    assign o_out_data.event_res         = r_ev;
    assign o_out_data.read_data         = r_hit ? r_rd_data : 8'd0;
    assign o_out_data.oldest_length     = r_nonempty ? 9'(head_len) : 9'd0;
    assign o_out_data.frames_queued     = r_queued;
    assign o_out_data.inside_frame      = r_inside;
    assign o_out_data.dropped_frames    = r_dropped;

    a_cnt_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> r_open)
        else $error("decoded bytes held with no open frame");

    a_esc_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> r_open)
        else $error("escape pending outside a frame");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(FRAME_BYTES))
        else $error("frame byte count past slot size");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!fire || ev != kdfq_pkg::EV_FULL) |=> $stable(r_drop))
        else $error("drop count moved without a full-queue drop");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(store_we && len_we))
        else $error("byte store and length store in the same word");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import kdfq_pkg::*;

    localparam int FRAME        = FRAME_BYTES_DEF;
    localparam int SLOTS        = QUEUE_SLOTS_DEF;
    localparam int RANDOM_WORDS = 160;
    localparam int LONG_HOLD    = 150;
    localparam int LIMIT_CYCLES = 1_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    kiss_deframer_frame_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // deframer shadow state
    logic       in_frame = 1'b0;
    logic       esc_pending = 1'b0;
    int         byte_cnt = 0;
    logic [7:0] slot_bytes [SLOTS][FRAME];
    int         slot_len [SLOTS];
    int         wr_slot = 0;
    int         rd_slot = 0;
    logic [15:0] drop_cnt = '0;

    t_out_word  pending_results [$];
    t_out_word  want;
    int         event_tally [5] = '{default: 0};
    int         fail_count = 0;
    int         words_sent = 0;
    int         results_checked = 0;
    bit         idle_on = 1'b1;
    bit         long_hold_req = 1'b0;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word r;
    } t_script_row;

    // opening sequence; typed results only where obvious
    t_script_row opening_script [25] = '{
        '{'{MODE_NOP,     8'h00, 8'h00}, 1'b1, '{EV_NONE,   8'h00, 9'd0, 3'd0, 1'b0, 16'd0}},
        '{'{MODE_RX,      8'h55, 8'hAA}, 1'b1, '{EV_NONE,   8'h00, 9'd0, 3'd0, 1'b0, 16'd0}},
        '{'{MODE_READ,    8'h00, 8'h00}, 1'b1, '{EV_NONE,   8'h00, 9'd0, 3'd0, 1'b0, 16'd0}},
        '{'{MODE_RELEASE, 8'h00, 8'h00}, 1'b1, '{EV_NONE,   8'h00, 9'd0, 3'd0, 1'b0, 16'd0}},
        '{'{MODE_RX,      FEND,  8'h00}, 1'b1, '{EV_NONE,   8'h00, 9'd0, 3'd0, 1'b1, 16'd0}},
        '{'{MODE_RX,      FEND,  8'hFF}, 1'b1, '{EV_NONE,   8'h00, 9'd0, 3'd0, 1'b1, 16'd0}},
        '{'{MODE_RX,      8'h00, 8'h00}, 1'b0, '0},
        '{'{MODE_RX,      FESC,  8'h00}, 1'b0, '0},
        '{'{MODE_RX,      TFEND, 8'h00}, 1'b0, '0},
        '{'{MODE_RX,      FESC,  8'h00}, 1'b0, '0},
        '{'{MODE_RX,      TFESC, 8'h00}, 1'b0, '0},
        '{'{MODE_RX,      8'hFF, 8'h00}, 1'b0, '0},
        '{'{MODE_RX,      FEND,  8'h00}, 1'b1, '{EV_QUEUED, 8'h00, 9'd4, 3'd1, 1'b1, 16'd0}},
        '{'{MODE_READ,    8'h00, 8'h01}, 1'b0, '0},
        '{'{MODE_READ,    8'hFF, 8'h03}, 1'b0, '0},
        '{'{MODE_READ,    8'h00, 8'h04}, 1'b0, '0},
        '{'{MODE_READ,    8'h00, 8'hFF}, 1'b0, '0},
        '{'{MODE_RX,      FESC,  8'h00}, 1'b0, '0},
        '{'{MODE_RX,      FEND,  8'h00}, 1'b1, '{EV_NONE,   8'h00, 9'd4, 3'd1, 1'b1, 16'd0}},
        '{'{MODE_RX,      8'h11, 8'h00}, 1'b0, '0},
        '{'{MODE_RX,      FESC,  8'h00}, 1'b0, '0},
        '{'{MODE_RX,      8'h41, 8'h00}, 1'b1, '{EV_BADESC, 8'h00, 9'd4, 3'd1, 1'b0, 16'd0}},
        '{'{MODE_RX,      8'h22, 8'h00}, 1'b0, '0},
        '{'{MODE_RELEASE, 8'h00, 8'h00}, 1'b1, '{EV_NONE,   8'h00, 9'd0, 3'd0, 1'b0, 16'd0}},
        '{'{MODE_NOP,     8'hFF, 8'hFF}, 1'b1, '{EV_NONE,   8'h00, 9'd0, 3'd0, 1'b0, 16'd0}}
    };

    function automatic int ring_used();
        return (wr_slot + SLOTS - rd_slot) % SLOTS;
    endfunction

    function automatic void drop_open_frame();
        in_frame    = 1'b0;
        esc_pending = 1'b0;
        byte_cnt    = 0;
    endfunction

    function automatic t_event keep_byte(input logic [7:0] b);
        if (byte_cnt >= FRAME) begin
            drop_open_frame();
            return EV_LONG;
        end
        slot_bytes[wr_slot][byte_cnt] = b;
        byte_cnt++;
        return EV_NONE;
    endfunction

    function automatic t_out_word predict_word(input t_in_word w);
        t_out_word r;
        t_event    ev;
        r  = '0;
        ev = EV_NONE;
        case (t_mode'(w.mode))
            MODE_RX: begin
                if (w.rx_byte == FEND) begin
                    if (in_frame && byte_cnt > 0) begin
                        if ((wr_slot + 1) % SLOTS == rd_slot) begin
                            ev = EV_FULL;
                            if (drop_cnt != 16'hFFFF)
                                drop_cnt++;
                        end else begin
                            slot_len[wr_slot] = byte_cnt;
                            wr_slot = (wr_slot + 1) % SLOTS;
                            ev = EV_QUEUED;
                        end
                    end
                    in_frame    = 1'b1;
                    esc_pending = 1'b0;
                    byte_cnt    = 0;
                end else if (in_frame) begin
                    if (esc_pending) begin
                        esc_pending = 1'b0;
                        if (w.rx_byte == TFEND)
                            ev = keep_byte(FEND);
                        else if (w.rx_byte == TFESC)
                            ev = keep_byte(FESC);
                        else begin
                            drop_open_frame();
                            ev = EV_BADESC;
                        end
                    end else if (w.rx_byte == FESC) begin
                        esc_pending = 1'b1;
                    end else begin
                        ev = keep_byte(w.rx_byte);
                    end
                end
            end
            MODE_READ: begin
                if (ring_used() != 0 && int'(w.read_index) < slot_len[rd_slot])
                    r.read_data = slot_bytes[rd_slot][w.read_index];
            end
            MODE_RELEASE: begin
                if (ring_used() != 0)
                    rd_slot = (rd_slot + 1) % SLOTS;
            end
            default: ;
        endcase
        if (ring_used() != 0)
            r.oldest_length = 9'(slot_len[rd_slot]);
        r.event_res      = ev;
        r.frames_queued  = 3'(ring_used());
        r.inside_frame   = in_frame;
        r.dropped_frames = drop_cnt;
        event_tally[int'(ev)]++;
        return r;
    endfunction

    task automatic push_word(input t_in_word w, input bit typed, input t_out_word typed_res);
        t_out_word predicted;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_word(w);
        pending_results.push_back(typed ? typed_res : predicted);
        words_sent++;
    endtask

    task automatic op(input t_mode m, input logic [7:0] rx, input logic [7:0] idx);
        push_word(t_in_word'{mode: m, rx_byte: rx, read_index: idx}, 1'b0, '0);
    endtask

    task automatic rx_line(input logic [7:0] b);
        op(MODE_RX, b, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return FEND;
            1: return FESC;
            2: return TFEND;
            3: return TFESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one decoded byte, escaped on the line where needed
    task automatic send_data_byte(input logic [7:0] b);
        if (b == FEND) begin
            rx_line(FESC);
            rx_line(TFEND);
        end else if (b == FESC) begin
            rx_line(FESC);
            rx_line(TFESC);
        end else begin
            rx_line(b);
        end
    endtask

    task automatic send_frame(input int len);
        if (!in_frame || $urandom_range(0, 3) == 0)
            rx_line(FEND);
        repeat (len) send_data_byte(pick_byte());
        rx_line(FEND);
    endtask

    task automatic flag_mismatch(input string field, input int exp_val, input int got_val);
        fail_count++;
        $display("%0t ERROR %s: expected %0d, got %0d", $time, field, exp_val, got_val);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t ERROR result word: expected none, got %h", $time, o_out_data);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_out_data.event_res !== want.event_res)
                    flag_mismatch("event_res", want.event_res, o_out_data.event_res);
                if (o_out_data.read_data !== want.read_data)
                    flag_mismatch("read_data", want.read_data, o_out_data.read_data);
                if (o_out_data.oldest_length !== want.oldest_length)
                    flag_mismatch("oldest_length", want.oldest_length, o_out_data.oldest_length);
                if (o_out_data.frames_queued !== want.frames_queued)
                    flag_mismatch("frames_queued", want.frames_queued, o_out_data.frames_queued);
                if (o_out_data.inside_frame !== want.inside_frame)
                    flag_mismatch("inside_frame", want.inside_frame, o_out_data.inside_frame);
                if (o_out_data.dropped_frames !== want.dropped_frames)
                    flag_mismatch("dropped_frames", want.dropped_frames, o_out_data.dropped_frames);
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("%0t timeout: %0d results still outstanding", $time, pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int         random_end;
        int         next_toggle;
        int         pick;
        logic [7:0] bad;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_script[k])
            push_word(opening_script[k].w, opening_script[k].typed, opening_script[k].r);

        // result side holds off while words keep coming, so the input backs up
        long_hold_req = 1'b1;
        random_end  = words_sent + RANDOM_WORDS;
        next_toggle = words_sent + 120;
        while (words_sent < random_end) begin
            if (words_sent >= next_toggle) begin
                idle_on = ($urandom_range(0, 2) != 0);
                next_toggle += 120;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(17, 80)
                                                        : $urandom_range(1, 16));
            end else if (pick < 55) begin
                if (ring_used() != 0 && $urandom_range(0, 3) != 0)
                    op(MODE_READ, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, slot_len[rd_slot])));
                else
                    op(MODE_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (pick < 67) begin
                repeat ($urandom_range(1, 3))
                    op(MODE_RELEASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (pick < 72) begin
                // escape followed by something other than TFEND/TFESC
                if (!in_frame)
                    rx_line(FEND);
                repeat ($urandom_range(0, 3)) send_data_byte(pick_byte());
                rx_line(FESC);
                bad = 8'($urandom_range(0, 255));
                if (bad == TFEND || bad == TFESC || bad == FEND)
                    bad = 8'h00;
                rx_line(bad);
                rx_line(8'($urandom_range(0, 255)));
            end else if (pick < 78) begin
                rx_line(8'($urandom_range(0, 255)));
            end else if (pick < 82) begin
                op(MODE_NOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (pick < 86) begin
                op(t_mode'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                // delimiter straight after an escape
                repeat ($urandom_range(0, 2)) send_data_byte(pick_byte());
                rx_line(FESC);
                rx_line(FEND);
            end else begin
                // burst with no release: runs the ring full and drops
                repeat ($urandom_range(4, 10)) send_frame($urandom_range(1, 6));
            end
        end

        // frame of exactly FRAME bytes is kept, one more byte aborts it
        idle_on = 1'b1;
        while (ring_used() != 0)
            op(MODE_RELEASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        rx_line(FEND);
        repeat (FRAME - 1) rx_line(8'($urandom_range(0, 191)));
        send_data_byte(FEND);
        rx_line(FEND);
        op(MODE_READ, 8'h00, 8'hFF);
        op(MODE_READ, 8'h00, 8'h00);
        repeat (FRAME) rx_line(8'($urandom_range(0, 191)));
        rx_line(8'h33);
        rx_line(8'h44);
        rx_line(FEND);
        op(MODE_RELEASE, 8'h00, 8'h00);

        // last part, no idling: fill the ring and drop a few frames
        idle_on = 1'b0;
        while (ring_used() < SLOTS - 1)
            send_frame($urandom_range(1, 4));
        if (!in_frame)
            rx_line(FEND);
        repeat (4) begin
            rx_line(8'($urandom_range(0, 255) & 8'h7F));
            rx_line(FEND);
        end
        op(MODE_RELEASE, 8'h00, 8'h00);
        op(MODE_READ, 8'h00, 8'h00);
        op(MODE_RELEASE, 8'h00, 8'h00);
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d words in, %0d results checked against the shadow deframer.",
                 words_sent, results_checked);
        $display("Events seen: %0d queued, %0d ring-full drops, %0d bad escapes, %0d too long.",
                 event_tally[int'(EV_QUEUED)], event_tally[int'(EV_FULL)],
                 event_tally[int'(EV_BADESC)], event_tally[int'(EV_LONG)]);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
